@@ hdl/gsb_pkg.sv @@
// Shared constants, packed weight array type and helpers for the separable Gaussian blur.
`default_nettype none
package gsb_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_RADIUS = 4;

  localparam int PIX_W   = 32;
  localparam int LANES   = 4;
  localparam int WGT_W   = 16;
  localparam int NUM_WGT = 5;
  localparam int ACC_W   = 28;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the config port.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLUR_RADIUS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_C     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_1     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_2     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_3     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_4     = 3'd7;

  localparam logic [10:0] RST_FRAME_WIDTH  = 11'd1024;
  localparam logic [10:0] RST_FRAME_HEIGHT = 11'd1024;
  localparam logic [2:0]  RST_BLUR_RADIUS  = 3'd2;
  localparam logic [WGT_W-1:0] RST_WEIGHT_C = 16'd26386;
  localparam logic [WGT_W-1:0] RST_WEIGHT_1 = 16'd16003;
  localparam logic [WGT_W-1:0] RST_WEIGHT_2 = 16'd3571;
  localparam logic [WGT_W-1:0] RST_WEIGHT_3 = 16'd0;
  localparam logic [WGT_W-1:0] RST_WEIGHT_4 = 16'd0;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef logic [NUM_WGT-1:0][WGT_W-1:0] weights_t;

  // Weight for tap distance d; distances past the table weigh nothing.
  function automatic logic [WGT_W-1:0] tap_weight(input weights_t w, input logic [3:0] d);
    logic [WGT_W-1:0] r;
    r = '0;
    if (d < 4'(NUM_WGT)) r = w[d[2:0]];
    return r;
  endfunction

  // Add one pixel times weight into four lane accumulators.
  function automatic logic [LANES-1:0][ACC_W-1:0] lanes_mac(
      input logic [LANES-1:0][ACC_W-1:0] acc, input logic [PIX_W-1:0] pix,
      input logic [WGT_W-1:0] w);
    logic [LANES-1:0][ACC_W-1:0] r;
    for (int l = 0; l < LANES; l++) begin
      r[l] = acc[l] + ACC_W'(pix[8*l +: 8]) * ACC_W'(w);
    end
    return r;
  endfunction

  // Drop the fraction and clamp each lane to 255.
  function automatic logic [PIX_W-1:0] lanes_finish(input logic [LANES-1:0][ACC_W-1:0] acc);
    logic [PIX_W-1:0] r;
    r = '0;
    for (int l = 0; l < LANES; l++) begin
      r[8*l +: 8] = (|acc[l][ACC_W-1:24]) ? 8'hFF : acc[l][23:16];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/gsb_in_if.sv @@
// Input request channel: kind and pixel with valid/ready.
`default_nettype none
interface gsb_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] pixel_in;
  modport source (output valid, output kind, output pixel_in, input ready);
  modport sink (input valid, input kind, input pixel_in, output ready);
endinterface
`default_nettype wire

@@ hdl/gsb_out_if.sv @@
// Output request channel: blurred pixel and end-of-frame mark with valid/ready.
`default_nettype none
interface gsb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_out;
  logic        last_of_frame;
  modport source (output valid, output pixel_out, output last_of_frame, input ready);
  modport sink (input valid, input pixel_out, input last_of_frame, output ready);
endinterface
`default_nettype wire

@@ hdl/separable_gaussian_blur_rgba_top.sv @@
// Top level of the separable Gaussian blur: config registers, front, queue, back.
//
//  port     dir  handshake     payload
//  in_ch    in   valid/ready   kind, pixel_in
//  out_ch   out  valid/ready   pixel_out, last_of_frame
//  cfg_*    in   cfg_we only   cfg_index, cfg_data
//
// Each item in the back end (R = blur radius) takes, in order, one pass of the shared
// four-lane MAC over the row window, then the vertical taps, each an address state for
// the line-memory read and a data state to accumulate. Short items skip some of these.
// Reset is synchronous; it clears the window, counters and handshake state.
// The front keeps taking requests into a four-entry queue, until it is full, while the back works
// or the output register waits.
`default_nettype none
module separable_gaussian_blur_rgba_top #(
  parameter int MAX_WIDTH  = gsb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = gsb_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = gsb_pkg::DEF_MAX_RADIUS
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  gsb_in_if.sink                                  in_ch,
  gsb_out_if.source                               out_ch,
  input  wire logic                               cfg_we,
  input  wire logic [gsb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [gsb_pkg::CFG_DATA_W-1:0]     cfg_data
);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int RW  = $clog2(MAX_RADIUS + 1);
  localparam int TTW = $clog2(MAX_WIDTH*MAX_HEIGHT + 1);
  localparam int SPW = $clog2(MAX_RADIUS*MAX_WIDTH + MAX_RADIUS + 1);
  localparam int PW  = $clog2(MAX_WIDTH*MAX_HEIGHT + MAX_RADIUS*MAX_WIDTH + MAX_RADIUS + 1);
  localparam int QW  = PW + 33;

  logic [10:0] frame_width, frame_height;
  logic [2:0]  blur_radius;
  gsb_pkg::weights_t weights;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= gsb_pkg::RST_FRAME_WIDTH;
      frame_height <= gsb_pkg::RST_FRAME_HEIGHT;
      blur_radius  <= gsb_pkg::RST_BLUR_RADIUS;
      weights[0]   <= gsb_pkg::RST_WEIGHT_C;
      weights[1]   <= gsb_pkg::RST_WEIGHT_1;
      weights[2]   <= gsb_pkg::RST_WEIGHT_2;
      weights[3]   <= gsb_pkg::RST_WEIGHT_3;
      weights[4]   <= gsb_pkg::RST_WEIGHT_4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gsb_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[10:0];
        gsb_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[10:0];
        gsb_pkg::REG_BLUR_RADIUS:  blur_radius  <= cfg_data[2:0];
        gsb_pkg::REG_WEIGHT_C:     weights[0]   <= cfg_data;
        gsb_pkg::REG_WEIGHT_1:     weights[1]   <= cfg_data;
        gsb_pkg::REG_WEIGHT_2:     weights[2]   <= cfg_data;
        gsb_pkg::REG_WEIGHT_3:     weights[3]   <= cfg_data;
        gsb_pkg::REG_WEIGHT_4:     weights[4]   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  logic [WW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;
  logic [RW-1:0]  r_eff;
  logic [TTW-1:0] t_total;
  logic [SPW-1:0] span;

  assign w_eff = (frame_width == '0) ? WW'(1) :
                 (32'(frame_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(frame_width);
  assign h_eff = (frame_height == '0) ? HW'(1) :
                 (32'(frame_height) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(frame_height);
  assign r_eff = (32'(blur_radius) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(blur_radius);
  assign t_total = TTW'(32'(w_eff) * 32'(h_eff));
  assign span    = SPW'(32'(r_eff) * 32'(w_eff) + 32'(r_eff));

  logic          q_push, q_full, q_pop, q_valid;
  logic [QW-1:0] q_in, q_out;

  gsb_front #(.PW(PW), .TTW(TTW), .SPW(SPW)) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .t_total (t_total),
    .span    (span),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_in)
  );

  gsb_queue #(.WIDTH(QW), .DEPTH(4)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_out)
  );

  gsb_back #(
    .MAX_WIDTH (MAX_WIDTH), .MAX_HEIGHT (MAX_HEIGHT), .MAX_RADIUS (MAX_RADIUS),
    .PW (PW), .TTW (TTW), .SPW (SPW), .WW (WW), .HW (HW), .RW (RW)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .w_eff   (w_eff),
    .h_eff   (h_eff),
    .r_eff   (r_eff),
    .t_total (t_total),
    .span    (span),
    .weights (weights),
    .out_ch  (out_ch)
  );
endmodule
`default_nettype wire

@@ hdl/gsb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gsb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ hdl/gsb_queue.sv @@
// Short FIFO between the front and the back.
`default_nettype none
module gsb_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic      [WIDTH-1:0] pop_data
);
  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wptr, rptr;
  logic [AW:0]      count;

  assign full      = (count == (AW+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) slots[wptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full) wptr <= (wptr == AW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      if (pop && not_empty) rptr <= (rptr == AW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      count <= count + (AW+1)'(push && !full) - (AW+1)'(pop && not_empty);
    end
  end
endmodule
`default_nettype wire

@@ hdl/gsb_front.sv @@
// Front end: accepts requests, tracks stream position, drops early flushes.
`default_nettype none
module gsb_front #(
  parameter int PW  = 21,
  parameter int TTW = 21,
  parameter int SPW = 13
) (
  input  wire logic           clk,
  input  wire logic           rst,
  gsb_in_if.sink              in_ch,
  input  wire logic [TTW-1:0] t_total,
  input  wire logic [SPW-1:0] span,
  input  wire logic           q_full,
  output logic                q_push,
  output logic [PW+33-1:0]    q_data
);
  logic [PW-1:0] pos;
  logic          in_frame, wrap, take;
  logic [31:0]   sample;

  assign in_ch.ready = !q_full;
  assign take     = in_ch.valid && !q_full;
  assign in_frame = 32'(pos) < 32'(t_total);
  assign wrap     = 32'(pos) >= 32'(span) + 32'(t_total) - 32'd1;
  assign sample   = in_frame ? in_ch.pixel_in : '0;
  // Drop a flush that arrives before the frame is complete.
  assign q_push   = take && !(in_frame && in_ch.kind == gsb_pkg::KIND_FLUSH);
  assign q_data   = {wrap, pos, sample};

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (q_push) begin
      pos <= wrap ? '0 : pos + 1'b1;
    end
  end
endmodule
`default_nettype wire

@@ hdl/gsb_back.sv @@
// Back end: row window, horizontal and vertical tap sequencing, output register.
`default_nettype none
module gsb_back #(
  parameter int MAX_WIDTH  = gsb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = gsb_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = gsb_pkg::DEF_MAX_RADIUS,
  parameter int PW  = 21,
  parameter int TTW = 21,
  parameter int SPW = 13,
  parameter int WW  = 11,
  parameter int HW  = 11,
  parameter int RW  = 3
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    q_valid,
  input  wire logic [PW+33-1:0]        q_data,
  output logic                         q_pop,
  input  wire logic [WW-1:0]           w_eff,
  input  wire logic [HW-1:0]           h_eff,
  input  wire logic [RW-1:0]           r_eff,
  input  wire logic [TTW-1:0]          t_total,
  input  wire logic [SPW-1:0]          span,
  input  wire gsb_pkg::weights_t       weights,
  gsb_out_if.source                    out_ch
);
  localparam int WIN   = 2*MAX_RADIUS + 1;
  localparam int WIX   = $clog2(WIN);
  localparam int TW    = $clog2(WIN + 1);
  localparam int DEPTH = MAX_WIDTH*2*MAX_RADIUS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int NRW   = $clog2(MAX_HEIGHT);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_HORZ  = 5'b00010,
    S_VADDR = 5'b00100,
    S_VDATA = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [31:0]   win [WIN];
  logic          wrap, fresh_ok, out_ok, last;
  logic [TW-1:0] t;
  logic [gsb_pkg::LANES-1:0][gsb_pkg::ACC_W-1:0] acc;
  logic [31:0]   fresh;
  logic [CW-1:0] hc, nc;
  logic [NRW-1:0] nr;
  logic [AW-1:0] wp, rb, addr;
  logic          ov;
  logic [31:0]   opix;
  logic          olast;
  logic [31:0]   rdata;

  logic [PW-1:0] qp;
  logic [31:0]   qs;
  logic          qwrap;
  logic          q_fresh, q_out, q_last;
  logic [3:0]    tap_dist;
  logic [gsb_pkg::WGT_W-1:0] wsel;
  logic          h_in, v_in, out_free, proceed, store_we;
  logic [31:0]   rwp, a0, astep;
  logic [31:0]   vval;

  assign {qwrap, qp, qs} = q_data;
  assign q_fresh = 32'(qp) >= 32'(r_eff) && 32'(qp) < 32'(t_total) + 32'(r_eff);
  assign q_out   = 32'(qp) >= 32'(span) && 32'(qp) < 32'(span) + 32'(t_total);
  assign q_last  = 32'(qp) == 32'(span) + 32'(t_total) - 32'd1;
  assign q_pop   = (state == S_IDLE) && q_valid;

  assign tap_dist = (32'(t) >= 32'(r_eff)) ? 4'(32'(t) - 32'(r_eff)) :
                                             4'(32'(r_eff) - 32'(t));
  assign wsel = gsb_pkg::tap_weight(weights, tap_dist);
  assign h_in = 32'(hc) + 32'(t) >= 32'(r_eff) &&
                32'(hc) + 32'(t) < 32'(w_eff) + 32'(r_eff);
  assign v_in = 32'(nr) + 32'(t) >= 32'(r_eff) &&
                32'(nr) + 32'(t) < 32'(h_eff) + 32'(r_eff);
  assign vval = (32'(t) == 32'(r_eff) * 2 && fresh_ok) ? fresh : rdata;

  assign rwp   = 32'(r_eff) * 32'(w_eff);
  assign a0    = (32'(rb) >= rwp) ? 32'(rb) - rwp : 32'(rb) + 32'(DEPTH) - rwp;
  assign astep = (32'(addr) + 32'(w_eff) >= 32'(DEPTH)) ?
                 32'(addr) + 32'(w_eff) - 32'(DEPTH) : 32'(addr) + 32'(w_eff);

  assign out_free = !ov || out_ch.ready;
  assign proceed  = (state == S_DONE) && (!out_ok || out_free);
  assign store_we = proceed && fresh_ok;

  gsb_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_line (
    .clk   (clk),
    .we    (store_we),
    .waddr (wp),
    .wdata (fresh),
    .raddr (addr),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (q_valid) state_next = q_fresh ? S_HORZ : S_VADDR;
      S_HORZ:  if (32'(t) == 32'(r_eff) * 2) state_next = S_VADDR;
      S_VADDR: state_next = out_ok ? S_VDATA : S_DONE;
      S_VDATA: state_next = (32'(t) == 32'(r_eff) * 2) ? S_DONE : S_VADDR;
      S_DONE:  if (proceed) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Item datapath and tap sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WIN; i++) win[i] <= '0;
      hc <= '0;
      nc <= '0;
      nr <= '0;
      wp <= '0;
      rb <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            win[0] <= qs;
            for (int i = 1; i < WIN; i++) win[i] <= win[i-1];
            wrap     <= qwrap;
            fresh_ok <= q_fresh;
            out_ok   <= q_out;
            last     <= q_last;
            t        <= '0;
            acc      <= '0;
            addr     <= AW'(a0);
          end
        end
        S_HORZ: begin
          if (32'(t) == 32'(r_eff) * 2) begin
            fresh <= gsb_pkg::lanes_finish(
                       h_in ? gsb_pkg::lanes_mac(acc, win[WIX'(32'(r_eff) * 2 - 32'(t))], wsel)
                            : acc);
            t    <= '0;
            acc  <= '0;
          end else begin
            if (h_in) acc <= gsb_pkg::lanes_mac(acc, win[WIX'(32'(r_eff) * 2 - 32'(t))], wsel);
            t <= t + 1'b1;
          end
        end
        S_VADDR: begin
        end
        S_VDATA: begin
          if (v_in) acc <= gsb_pkg::lanes_mac(acc, vval, wsel);
          t    <= t + 1'b1;
          addr <= AW'(astep);
        end
        S_DONE: begin
          if (proceed) begin
            if (wrap) begin
              for (int i = 0; i < WIN; i++) win[i] <= '0;
              hc <= '0;
              nc <= '0;
              nr <= '0;
              wp <= '0;
              rb <= '0;
            end else begin
              if (fresh_ok) begin
                hc <= (32'(hc) == 32'(w_eff) - 1) ? '0 : hc + 1'b1;
                wp <= (32'(wp) == DEPTH - 1) ? '0 : wp + 1'b1;
              end
              if (out_ok) begin
                rb <= (32'(rb) == DEPTH - 1) ? '0 : rb + 1'b1;
                if (32'(nc) == 32'(w_eff) - 1) begin
                  nc <= '0;
                  nr <= nr + 1'b1;
                end else begin
                  nc <= nc + 1'b1;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output register: load on a finished item that produces output, hold until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (proceed && out_ok) begin
      ov <= 1'b1;
    end else if (out_ch.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed && out_ok) begin
      opix  <= gsb_pkg::lanes_finish(acc);
      olast <= last;
    end
  end

  assign out_ch.valid         = ov;
  assign out_ch.pixel_out     = opix;
  assign out_ch.last_of_frame = olast;
endmodule
`default_nettype wire
